// File: design/positional_list_get_insert_delete_top_defines.svh
// Assertion macros used by the positional list top-level design file.
`ifndef POSITIONAL_LIST_GET_INSERT_DELETE_TOP_DEFINES_SVH
`define POSITIONAL_LIST_GET_INSERT_DELETE_TOP_DEFINES_SVH
`ifndef SYNTH
// Checked property, disabled while reset is asserted.
`define PLGD_ASSERT_RST(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("property violated");
// Checked property, always active.
`define PLGD_ASSERT(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("property violated");
`else
`define PLGD_ASSERT_RST(lbl, clk, rstn, prop)
`define PLGD_ASSERT(lbl, clk, prop)
`endif
`endif

// File: design/plg_pkg.sv
// Package: request/result types, codes and tree sizing functions.
package plg_pkg;

    localparam int DATA_W = 32;
    localparam int POS_W  = 8;
    localparam int LEN_W  = 7;
    localparam int FANIN  = 8;

    localparam logic [1:0] MODE_GET = 2'd0;
    localparam logic [1:0] MODE_INS = 2'd1;
    localparam logic [1:0] MODE_DEL = 2'd2;

    localparam logic [1:0] STAT_OK     = 2'd0;
    localparam logic [1:0] STAT_BADPOS = 2'd1;
    localparam logic [1:0] STAT_FULL   = 2'd2;

    typedef struct packed {
        logic [1:0]              mode;
        logic [POS_W-1:0]        position;
        logic signed [DATA_W-1:0] new_value;
    } req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [DATA_W-1:0] read_value;
        logic [LEN_W-1:0]        length;
    } rsp_t;

    // Broadcast control for the row of storage cells.
    typedef struct packed {
        logic                    ins;
        logic                    del;
        logic                    cap;
        logic                    rd;
        logic [POS_W-1:0]        p;
        logic signed [DATA_W-1:0] value;
    } cell_ctl_t;

    // Node count of a given level of the reduction tree (level 0 = leaves).
    function automatic int plg_lvl_cnt(input int n, input int l);
        int c;
        c = n;
        for (int i = 0; i < 16; i++) begin
            if (i < l) c = (c + FANIN - 1) / FANIN;
        end
        return c;
    endfunction

    // Offset of a level in the flattened node array.
    function automatic int plg_lvl_off(input int n, input int l);
        int s;
        s = 0;
        for (int i = 0; i < 16; i++) begin
            if (i < l) s = s + plg_lvl_cnt(n, i);
        end
        return s;
    endfunction

    // Number of registered levels needed to reach a single root.
    function automatic int plg_levels(input int n);
        int c;
        int l;
        c = n;
        l = 0;
        for (int i = 0; i < 16; i++) begin
            if (c > 1) begin
                c = (c + FANIN - 1) / FANIN;
                l = l + 1;
            end
        end
        return l;
    endfunction

endpackage

// File: design/plg_cell.sv
// Storage cell: one list entry, shifts with its neighbors, taps its value for reads.
module plg_cell import plg_pkg::*; #(
    parameter int IDX = 0
) (
    input  logic                     aclk,
    input  cell_ctl_t                ctl,
    input  logic signed [DATA_W-1:0] left_val,
    input  logic signed [DATA_W-1:0] right_val,
    output logic signed [DATA_W-1:0] val,
    output logic [DATA_W-1:0]        tap
);

    logic signed [DATA_W-1:0] val_reg;
    logic [DATA_W-1:0]        tap_reg;
    logic                     at_p;
    logic                     past_p;

    assign at_p   = (IDX == int'(ctl.p));
    assign past_p = (IDX > int'(ctl.p));

    always_ff @(posedge aclk) begin
        if (ctl.ins) begin
            if (past_p) begin
                val_reg <= left_val;
            end else if (at_p) begin
                val_reg <= ctl.value;
            end
        end else if (ctl.del) begin
            if (past_p || at_p) begin
                val_reg <= right_val;
            end
        end
        // selected entry is sampled before any shift takes effect
        if (ctl.cap) begin
            tap_reg <= (ctl.rd && at_p) ? val_reg : '0;
        end
    end

    assign val = val_reg;
    assign tap = tap_reg;

endmodule

// File: design/plg_or_tree.sv
// Registered 8-way OR reduction tree that collects the one nonzero cell tap.
module plg_or_tree import plg_pkg::*; #(
    parameter int N = 64,
    parameter int W = 32
) (
    input  logic         aclk,
    input  logic [W-1:0] leaf [N],
    output logic [W-1:0] root
);

    localparam int LEVELS = plg_levels(N);
    localparam int TOTAL  = plg_lvl_off(N, LEVELS + 1);

    logic [W-1:0] node [TOTAL];

    for (genvar i = 0; i < N; i++) begin : g_leaf
        assign node[i] = leaf[i];
    end

    for (genvar l = 1; l <= LEVELS; l++) begin : g_lvl
        localparam int NC   = plg_lvl_cnt(N, l);
        localparam int NP   = plg_lvl_cnt(N, l - 1);
        localparam int OFF  = plg_lvl_off(N, l);
        localparam int POFF = plg_lvl_off(N, l - 1);
        for (genvar j = 0; j < NC; j++) begin : g_node
            logic [W-1:0] part [FANIN];
            logic [W-1:0] acc;
            for (genvar k = 0; k < FANIN; k++) begin : g_in
                if (j * FANIN + k < NP) begin : g_used
                    assign part[k] = node[POFF + j * FANIN + k];
                end else begin : g_pad
                    assign part[k] = '0;
                end
            end
            always_comb begin
                acc = '0;
                for (int k = 0; k < FANIN; k++) begin
                    acc = acc | part[k];
                end
            end
            always_ff @(posedge aclk) begin
                node[OFF + j] <= acc;
            end
        end
    end

    assign root = node[TOTAL-1];

endmodule

// File: design/positional_list_get_insert_delete_top.sv
// Positional list store: get, insert and delete by 1-based position over a row of cells.
//
//   channel | dir | handshake        | payload
//   --------+-----+------------------+-------------------------------------
//   s_      | in  | s_valid/s_ready  | s_data: mode, position, new_value
//   m_      | out | m_valid/m_ready  | m_data: status, read_value, length
//
// One request is handled at a time, in steps (LEVELS = ceil(log8(CAPACITY))):
// accept, execute (all cells shift at once), LEVELS stages of the registered
// OR tree that fetches the read value, then the output register load.
// Reset (aresetn low, synchronous) empties the list; entries keep no reset.
// The next request is taken while a result waits in the output register;
// the load stalls only while that register is still full.
`include "positional_list_get_insert_delete_top_defines.svh"
module positional_list_get_insert_delete_top import plg_pkg::*; #(
    parameter int CAPACITY = 64
) (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  req_t s_data,
    output logic m_valid,
    input  logic m_ready,
    output rsp_t m_data
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
    localparam int LEVELS = plg_levels(CAPACITY);
    localparam int RC_W   = $clog2(LEVELS + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EXEC = 2'd1;
    localparam logic [1:0] ST_RED  = 2'd2;

    logic [1:0]       state_reg, state_next;
    req_t             req_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [RC_W-1:0]  red_cnt_reg, red_cnt_next;
    logic [1:0]       status_reg, status_next;
    logic             m_valid_reg, m_valid_next;
    rsp_t             m_data_reg;

    logic [CMP_W-1:0] pos_x, cnt_x;
    logic             pos_nz, in_len, in_ins, full;
    logic             do_ins, do_del, do_rd;
    logic             load_out;
    cell_ctl_t        ctl;

    logic signed [DATA_W-1:0] cell_val [CAPACITY];
    logic [DATA_W-1:0]        cell_tap [CAPACITY];
    logic [DATA_W-1:0]        root;

    assign pos_x  = CMP_W'(req_reg.position);
    assign cnt_x  = CMP_W'(count_reg);
    assign pos_nz = (req_reg.position != '0);
    assign in_len = pos_nz && (pos_x <= cnt_x);
    assign in_ins = pos_nz && (pos_x <= cnt_x + CMP_W'(1));
    assign full   = (count_reg == CNT_W'(CAPACITY));

    always_comb begin
        do_ins      = 1'b0;
        do_del      = 1'b0;
        do_rd       = 1'b0;
        status_next = STAT_BADPOS;
        unique case (req_reg.mode)
            MODE_GET: begin
                if (in_len) begin
                    do_rd       = 1'b1;
                    status_next = STAT_OK;
                end
            end
            MODE_INS: begin
                if (in_ins) begin
                    if (full) begin
                        status_next = STAT_FULL;
                    end else begin
                        do_ins      = 1'b1;
                        status_next = STAT_OK;
                    end
                end
            end
            MODE_DEL: begin
                if (in_len) begin
                    do_del      = 1'b1;
                    do_rd       = 1'b1;
                    status_next = STAT_OK;
                end
            end
            default: begin
                status_next = STAT_BADPOS;
            end
        endcase
    end

    always_comb begin
        ctl.cap   = (state_reg == ST_EXEC);
        ctl.ins   = ctl.cap && do_ins;
        ctl.del   = ctl.cap && do_del;
        ctl.rd    = do_rd;
        ctl.p     = req_reg.position - POS_W'(1);
        ctl.value = req_reg.new_value;
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic signed [DATA_W-1:0] left_val;
        logic signed [DATA_W-1:0] right_val;
        if (i == 0) begin : g_first
            assign left_val = '0;
        end else begin : g_left
            assign left_val = cell_val[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_val = '0;
        end else begin : g_right
            assign right_val = cell_val[i+1];
        end
        plg_cell #(
            .IDX(i)
        ) u_cell (
            .aclk      (aclk),
            .ctl       (ctl),
            .left_val  (left_val),
            .right_val (right_val),
            .val       (cell_val[i]),
            .tap       (cell_tap[i])
        );
    end

    plg_or_tree #(
        .N(CAPACITY),
        .W(DATA_W)
    ) u_tree (
        .aclk (aclk),
        .leaf (cell_tap),
        .root (root)
    );

    assign load_out = (state_reg == ST_RED) && (red_cnt_reg == RC_W'(LEVELS))
                      && (!m_valid_reg || m_ready);

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        red_cnt_next = red_cnt_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (do_ins) begin
                    count_next = count_reg + CNT_W'(1);
                end else if (do_del) begin
                    count_next = count_reg - CNT_W'(1);
                end
                red_cnt_next = '0;
                state_next   = ST_RED;
            end
            ST_RED: begin
                if (red_cnt_reg != RC_W'(LEVELS)) begin
                    red_cnt_next = red_cnt_reg + RC_W'(1);
                end else if (load_out) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            red_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            red_cnt_reg <= red_cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg <= s_data;
        end
        if (state_reg == ST_EXEC) begin
            status_reg <= status_next;
        end
        if (load_out) begin
            m_data_reg.status     <= status_reg;
            m_data_reg.read_value <= root;
            m_data_reg.length     <= LEN_W'(count_reg);
        end
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `PLGD_ASSERT_RST(a_count_bound, aclk, aresetn, count_reg <= CNT_W'(CAPACITY))
    `PLGD_ASSERT_RST(a_accept_exec, aclk, aresetn, (s_valid && s_ready) |=> (state_reg == ST_EXEC))
    `PLGD_ASSERT_RST(a_get_keeps_len, aclk, aresetn, ((state_reg == ST_EXEC) && (req_reg.mode == MODE_GET)) |=> $stable(count_reg))
    `PLGD_ASSERT_RST(a_len_only_exec, aclk, aresetn, (state_reg != ST_EXEC) |=> $stable(count_reg))

endmodule
